>>> hdl/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  owner_id;
        logic [7:0]  owner_state;
        logic [15:0] page_number;
        logic [5:0]  frame_index;
    } t_pfa_in;

    typedef struct packed {
        logic        status;
        logic [5:0]  granted_frame;
        logic [6:0]  frames_freed;
        logic        table_empty;
    } t_pfa_out;

endpackage

`default_nettype wire

>>> hdl/page_frame_allocator.sv
`default_nettype none

// First-fit page frame allocator. The frame table (valid, owner, owner state,
// page) lives in one single-port-write, one-read synchronous memory, and
// allocate, free and release read, modify and write it back one entry per
// cycle; a running count of owned frames gives table_empty and lets a
// full-table allocate answer at once. After reset a clearing pass writes
// every entry before the first item is taken. One item is worked at a time:
// allocate sweeps up to the lowest free frame, free reads the entry named and
// clears it if valid, and release sweeps the whole table. The result sits in
// an output register, so the next item can be taken while it waits.

module page_frame_allocator #(
    parameter int FRAME_COUNT = 64,
    parameter int OWNER_BITS  = 8,
    parameter int PAGE_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pfa_pkg::t_pfa_in   i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pfa_pkg::t_pfa_out       o_out
);

    import pfa_pkg::*;

    localparam int IDX_W   = $clog2(FRAME_COUNT);
    localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
    localparam int ENTRY_W = 1 + OWNER_BITS + 8 + PAGE_BITS;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_COUNT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_FREE_RD,
        S_FREE_CHK,
        S_PUSH
    } t_state;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_ptr;
    logic                   r_issue;
    logic                   r_chk;
    logic [IDX_W-1:0]       r_chk_addr;
    logic                   r_is_alloc;
    logic [ENTRY_W-1:0]     r_new_entry;
    logic [OWNER_BITS-1:0]  r_owner;
    logic [CNT_W-1:0]       r_owned;
    logic                   r_status;
    logic [5:0]             r_granted;
    logic [CNT_W-1:0]       r_freed;
    logic                   r_out_valid;
    t_pfa_out               r_out;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   rd_valid;
    logic [OWNER_BITS-1:0]  rd_owner;
    logic                   owner_hit;

    // input fields brought to the table widths
    logic [OWNER_BITS+7:0]  owner_ext;
    logic [PAGE_BITS+15:0]  page_ext;
    logic [IDX_W+5:0]       idx_ext;
    logic                   idx_in_range;
    logic [IDX_W+5:0]       granted_ext;
    logic [CNT_W+6:0]       freed_ext;

    assign owner_ext    = {{OWNER_BITS{1'b0}}, i_in.owner_id};
    assign page_ext     = {{PAGE_BITS{1'b0}}, i_in.page_number};
    assign idx_ext      = {{IDX_W{1'b0}}, i_in.frame_index};
    assign idx_in_range = idx_ext < (IDX_W + 6)'(FRAME_COUNT);
    assign granted_ext  = {6'd0, r_chk_addr};
    assign freed_ext    = {7'd0, r_freed};

    assign rd_valid  = rd_data[ENTRY_W-1];
    assign rd_owner  = rd_data[ENTRY_W-2 -: OWNER_BITS];
    assign owner_hit = rd_valid && (rd_owner == r_owner);

    pfa_table #(
        .DEPTH (FRAME_COUNT),
        .WIDTH (ENTRY_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_chk_addr;
        wr_data = r_new_entry;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = '0;
            end
            S_SWEEP: begin
                if (r_chk) begin
                    if (r_is_alloc && !rd_valid) begin
                        wr_en = 1'b1;
                    end else if (!r_is_alloc && owner_hit) begin
                        wr_en   = 1'b1;
                        wr_data = '0;
                    end
                end
            end
            S_FREE_CHK: begin
                wr_en   = rd_valid;
                wr_addr = r_ptr;
                wr_data = '0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_owned     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_PUSH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_ptr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + IDX_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_new_entry <= {1'b1, owner_ext[OWNER_BITS-1:0], i_in.owner_state,
                                        page_ext[PAGE_BITS-1:0]};
                        r_owner     <= owner_ext[OWNER_BITS-1:0];
                        r_status    <= STATUS_DONE;
                        r_granted   <= '0;
                        r_freed     <= '0;
                        r_chk       <= 1'b0;
                        unique case (i_in.command)
                            CMD_ALLOC: begin
                                if (r_owned == FULL_CNT) begin
                                    r_status <= STATUS_FULL;
                                    r_state  <= S_PUSH;
                                end else begin
                                    r_is_alloc <= 1'b1;
                                    r_ptr      <= '0;
                                    r_issue    <= 1'b1;
                                    r_state    <= S_SWEEP;
                                end
                            end
                            CMD_FREE: begin
                                if (idx_in_range) begin
                                    r_ptr   <= idx_ext[IDX_W-1:0];
                                    r_state <= S_FREE_RD;
                                end else begin
                                    r_state <= S_PUSH;
                                end
                            end
                            CMD_RELEASE: begin
                                r_is_alloc <= 1'b0;
                                r_ptr      <= '0;
                                r_issue    <= 1'b1;
                                r_state    <= S_SWEEP;
                            end
                            default: begin
                                r_state <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    // read address runs one entry ahead of the entry being checked
                    r_chk      <= r_issue;
                    r_chk_addr <= r_ptr;
                    if (r_issue) begin
                        if (r_ptr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr + IDX_W'(1);
                        end
                    end
                    if (r_chk) begin
                        if (r_is_alloc && !rd_valid) begin
                            r_granted <= granted_ext[5:0];
                            r_owned   <= r_owned + CNT_W'(1);
                            r_state   <= S_PUSH;
                        end else begin
                            if (!r_is_alloc && owner_hit) begin
                                r_freed <= r_freed + CNT_W'(1);
                                r_owned <= r_owned - CNT_W'(1);
                            end
                            if (r_chk_addr == LAST_IDX) begin
                                if (r_is_alloc) begin
                                    r_status <= STATUS_FULL;
                                end
                                r_state <= S_PUSH;
                            end
                        end
                    end
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    if (rd_valid) begin
                        r_freed <= CNT_W'(1);
                        r_owned <= r_owned - CNT_W'(1);
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid         <= 1'b1;
                        r_out.status        <= r_status;
                        r_out.granted_frame <= r_granted;
                        r_out.frames_freed  <= freed_ext[6:0];
                        r_out.table_empty   <= (r_owned == '0);
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> hdl/pfa_table.sv
`default_nettype none

module pfa_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
